// ===== hdl/aes_pkg.sv =====
// Shared types and byte codes for the ANSI escape stripper.
package aes_pkg;

  // Parser states
  typedef enum logic [2:0] {
    ST_NORMAL  = 3'd0,
    ST_ESC     = 3'd1,
    ST_CSI     = 3'd2,
    ST_OSC     = 3'd3,
    ST_OSC_ESC = 3'd4,
    ST_CHARSET = 3'd5
  } parse_state_e;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_CSI8   = 8'h9B;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] FINAL_LO  = 8'h40;
  localparam logic [7:0] FINAL_HI  = 8'h7E;

  // One input byte with its chunk end mark
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } aes_item_t;

  // One classified byte
  typedef struct packed {
    logic [7:0] data;
    logic       keep;
    logic       last;
  } aes_result_t;

endpackage

// ===== hdl/aes_in_stage.sv =====
// Input register stage of the ANSI escape stripper.
module aes_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  aes_pkg::aes_item_t item_i,
  output logic               valid_o,
  input  logic               advance_i,
  output aes_pkg::aes_item_t item_o
);
  import aes_pkg::*;

  logic      valid_q, valid_d;
  aes_item_t item_q;
  logic      take;

  assign ready_o = !valid_q || advance_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/aes_parser.sv =====
// Escape sequence parse state and per-byte keep decision.
module aes_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 strip_en_i,
  input  logic                 step_i,
  input  aes_pkg::aes_item_t   item_i,
  output aes_pkg::aes_result_t res_o
);
  import aes_pkg::*;

  parse_state_e state_q, state_d;
  logic         keep;
  logic [7:0]   c;

  assign c = item_i.data;

  always_comb begin
    state_d = state_q;
    keep    = 1'b0;
    if (!strip_en_i) begin
      keep = 1'b1;
    end else begin
      case (state_q)
        ST_NORMAL: begin
          if (c == CH_ESC) begin
            state_d = ST_ESC;
          end else if (c == CH_CSI8) begin
            state_d = ST_CSI;
          end else begin
            keep = 1'b1;
          end
        end
        ST_ESC: begin
          if (c == CH_LBRACK) begin
            state_d = ST_CSI;
          end else if (c == CH_RBRACK) begin
            state_d = ST_OSC;
          end else if (c == CH_LPAREN || c == CH_RPAREN) begin
            state_d = ST_CHARSET;
          end else begin
            state_d = ST_NORMAL;
          end
        end
        ST_CSI: begin
          if (c inside {[FINAL_LO:FINAL_HI]}) begin
            state_d = ST_NORMAL;
          end
        end
        ST_OSC: begin
          if (c == CH_BEL) begin
            state_d = ST_NORMAL;
          end else if (c == CH_ESC) begin
            state_d = ST_OSC_ESC;
          end
        end
        ST_OSC_ESC, ST_CHARSET: begin
          state_d = ST_NORMAL;
        end
        default: begin
          state_d = ST_NORMAL;
          keep    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_NORMAL;
    end else if (step_i && strip_en_i) begin
      state_q <= state_d;
    end
  end

  assign res_o.data = item_i.data;
  assign res_o.keep = keep;
  assign res_o.last = item_i.last;

`ifndef SYNTHESIS
  a_state_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(state_q))
    else $error("parse state moved without a byte");

  a_esc_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strip_en_i && (state_q == ST_ESC || state_q == ST_CSI)) |-> !res_o.keep)
    else $error("byte inside escape sequence was kept");

  a_csi8_enters_csi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && strip_en_i && state_q == ST_NORMAL && item_i.data == CH_CSI8)
      |=> state_q == ST_CSI)
    else $error("8-bit CSI did not enter CSI state");

  a_bypass_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !strip_en_i |-> res_o.keep)
    else $error("byte dropped while stripping disabled");
`endif

endmodule

// ===== hdl/aes_out_stage.sv =====
// Result register stage of the ANSI escape stripper.
module aes_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 advance_o,
  input  aes_pkg::aes_result_t res_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output aes_pkg::aes_result_t res_o
);
  import aes_pkg::*;

  logic        valid_q, valid_d;
  aes_result_t res_q;

  // Register frees up when empty or when its transfer completes
  assign advance_o = valid_i && (!valid_q || ready_i);

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== hdl/ansi_escape_stripper.sv =====
// Top level of the ANSI escape sequence stripper.
//
//  Channel   Dir  Payload                                 Transfer when
//  s_axis    in   tdata = in_byte, tlast = chunk_end       tvalid & tready
//  m_axis    out  tdata = out_byte, tuser = out_keep,      tvalid & tready
//                 tlast = out_chunk_end
//  cfg       in   cfg_wdata_i = strip_enable               cfg_we_i
//
// One byte per cycle sustained while m_axis accepts. A byte sits in the input
// register, then the parse logic loads it into the result register when that
// has room, so its result passes through the input and result registers.
// The single parse state register is the only loop, updated once per byte
// while stripping is enabled. Reset (async, active low) empties both stages,
// sets the parser to normal text and clears strip_enable.
// A stall on m_axis backs up through the result and input registers; the
// input side keeps accepting while either stage has room.
module ansi_escape_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,    // strip_enable
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // chunk_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] out_keep
  output logic       m_axis_tlast    // out_chunk_end
);
  import aes_pkg::*;

  logic        strip_en_q;
  aes_item_t   in_item, stage_item;
  logic        stage_valid, advance;
  aes_result_t parse_res, out_res;

  // Configuration register; the user must write it only while the block is idle, which the block does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      strip_en_q <= cfg_wdata_i;
    end
  end

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  aes_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .valid_o   (stage_valid),
    .advance_i (advance),
    .item_o    (stage_item)
  );

  // Parse state steps when the held byte moves into the result register while stripping is enabled
  aes_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .strip_en_i (strip_en_q),
    .step_i     (advance),
    .item_i     (stage_item),
    .res_o      (parse_res)
  );

  aes_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stage_valid),
    .advance_o (advance),
    .res_i     (parse_res),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .res_o     (out_res)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tuser = out_res.keep;
  assign m_axis_tlast = out_res.last;

endmodule
